// File: rtl/assert_macros.svh
// Assertion macros shared by the CRC engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CCRC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CCRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ccrc_pkg.sv
// Types, constants and helper functions of the configurable CRC engine.
package ccrc_pkg;

  localparam int CrcW = 32;
  localparam int CfgIdxW = 8;
  localparam int WidthW = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_REFLECTED = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CRC_WIDTH = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_POLYNOMIAL = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_VALUE = 8'd3;

  // Reset values of the configuration registers.
  localparam logic RESET_REFLECTED = 1'b1;
  localparam logic [WidthW-1:0] RESET_CRC_WIDTH = 6'd32;
  localparam logic [CrcW-1:0] RESET_POLYNOMIAL = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] RESET_INITIAL_VALUE = 32'h0000_0000;

  localparam logic [WidthW-1:0] MIN_CRC_WIDTH = 6'd8;
  localparam logic [WidthW-1:0] MAX_CRC_WIDTH = 6'd32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } ccrc_in_t;

  typedef struct packed {
    logic [CrcW-1:0] crc_value;
    logic            message_done;
    logic            config_error;
  } ccrc_out_t;

  // Decoded configuration handed from the register file to the datapath.
  typedef struct packed {
    logic            reflected;
    logic [CrcW-1:0] polynomial;
    logic [CrcW-1:0] poly_aligned;
    logic [CrcW-1:0] initial_value;
    logic            config_error;
  } ccrc_cfg_t;

  function automatic logic [CrcW-1:0] swap_bytes(input logic [CrcW-1:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// File: rtl/ccrc_cfg_regs.sv
// Configuration registers of the CRC engine and their decoding.
module ccrc_cfg_regs import ccrc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CrcW-1:0]     wr_data,
  output ccrc_cfg_t           cfg
);

  logic              reflected_r;
  logic [WidthW-1:0] crc_width_r;
  logic [CrcW-1:0]   polynomial_r;
  logic [CrcW-1:0]   initial_value_r;
  logic [WidthW-1:0] align_sh;
  logic              width_bad;
  logic              poly_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reflected_r     <= RESET_REFLECTED;
      crc_width_r     <= RESET_CRC_WIDTH;
      polynomial_r    <= RESET_POLYNOMIAL;
      initial_value_r <= RESET_INITIAL_VALUE;
    end else if (wr_en) begin
      case (wr_index)
        CFG_REFLECTED:     reflected_r     <= wr_data[0];
        CFG_CRC_WIDTH:     crc_width_r     <= wr_data[WidthW-1:0];
        CFG_POLYNOMIAL:    polynomial_r    <= wr_data;
        CFG_INITIAL_VALUE: initial_value_r <= wr_data;
        default: ;
      endcase
    end
  end

  // A shift by the full width yields zero, so a 32-bit CRC never flags here.
  assign width_bad = (crc_width_r < MIN_CRC_WIDTH) || (crc_width_r > MAX_CRC_WIDTH);
  assign poly_bad  = (polynomial_r >> crc_width_r) != '0;
  assign align_sh  = MAX_CRC_WIDTH - crc_width_r;

  assign cfg.reflected     = reflected_r;
  assign cfg.polynomial    = polynomial_r;
  assign cfg.poly_aligned  = polynomial_r << align_sh;
  assign cfg.initial_value = initial_value_r;
  assign cfg.config_error  = width_bad || poly_bad;

endmodule

// File: rtl/ccrc_fold.sv
// One-byte CRC fold: optional initial load, then eight shift/XOR steps.
module ccrc_fold import ccrc_pkg::*; (
  input  ccrc_cfg_t       cfg,
  input  logic [CrcW-1:0] crc_cur,
  input  logic [7:0]      data_byte,
  input  logic            first_byte,
  output logic [CrcW-1:0] crc_next
);

  logic [CrcW-1:0] base;
  logic [7:0]      idx;
  logic [CrcW-1:0] c_ref;
  logic [CrcW-1:0] c_msb;
  logic [CrcW-1:0] term;

  assign base = first_byte ? cfg.initial_value : crc_cur;
  assign idx  = base[7:0] ^ data_byte;

  always_comb begin
    c_ref = {24'd0, idx};
    c_msb = {idx, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c_ref = (c_ref >> 1) ^ (c_ref[0] ? cfg.polynomial : '0);
      c_msb = (c_msb << 1) ^ (c_msb[CrcW-1] ? cfg.poly_aligned : '0);
    end
    term = cfg.reflected ? c_ref : swap_bytes(c_msb);
  end

  // The register is kept byte-swapped in MSB-first mode, so the same
  // right shift applies to both bit orders.
  assign crc_next = term ^ (base >> 8);

endmodule

// File: rtl/configurable_crc_engine.sv
// Top level of the byte-wide configurable CRC engine.
//
// Usage: message bytes enter on the in_ channel (valid/ready), one byte per
// transfer. A byte with first_byte set loads initial_value before it is
// folded; last_byte is echoed as message_done. Each input transfer yields
// exactly one result transfer on the out_ channel carrying the running CRC.
// A byte waits in the input register and is folded on its way into the
// result register, which holds the result until the out_ channel takes it.
// One byte is taken per cycle while the receiver does not stall; the
// combinational eight-step fold closes the loop through the CRC register.
// Configuration registers are written through the cfg_ channel, which is
// always ready; writes are expected only while no byte is in flight.
// An invalid width or polynomial gives config_error = 1 and crc_value = 0,
// and the CRC register keeps its value.
// Reset (synchronous, active low) empties both stages, clears the CRC
// register and restores the default configuration (reflected CRC-32).
// When the receiver stalls, the result register holds its transfer, the
// input register can still take one more byte, and only then does in_ready
// drop.
`include "assert_macros.svh"

module configurable_crc_engine import ccrc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccrc_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ccrc_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CrcW-1:0]    cfg_data
);

  ccrc_cfg_t       cfg;
  logic            stage_valid_r;
  logic            stage_valid_nxt;
  ccrc_in_t        stage_data_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  ccrc_out_t       out_data_r;
  ccrc_out_t       out_data_nxt;
  logic [CrcW-1:0] crc_r;
  logic [CrcW-1:0] crc_nxt;
  logic [CrcW-1:0] crc_fold;
  logic            advance;
  logic            in_fire;

  assign cfg_ready = 1'b1;

  ccrc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ccrc_fold u_fold (
    .cfg        (cfg),
    .crc_cur    (crc_r),
    .data_byte  (stage_data_r.data_byte),
    .first_byte (stage_data_r.first_byte),
    .crc_next   (crc_fold)
  );

  // The held byte moves into the result register when that register is
  // empty or its current result is being taken in this cycle.
  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_fire) begin
      stage_valid_nxt = 1'b1;
    end else if (advance) begin
      stage_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // A bad configuration leaves the CRC register untouched and reports zero.
    crc_nxt                   = crc_r;
    out_data_nxt.crc_value    = '0;
    out_data_nxt.message_done = stage_data_r.last_byte;
    out_data_nxt.config_error = cfg.config_error;
    if (!cfg.config_error) begin
      crc_nxt                = crc_fold;
      out_data_nxt.crc_value = crc_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      crc_r         <= '0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (advance) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A flagged result never carries a CRC value.
  `CCRC_ASSERT_SAME(a_err_zero,
    out_valid_r && out_data_r.config_error,
    out_data_r.crc_value == '0,
    "config_error result with nonzero CRC")

  // A byte processed under a bad configuration must not disturb the CRC state.
  `CCRC_ASSERT_NEXT(a_err_hold,
    advance && cfg.config_error,
    crc_r == $past(crc_r),
    "CRC register changed under bad configuration")

  // Both stages full and the receiver stalled: no further input is taken.
  `CCRC_ASSERT_SAME(a_full_block,
    stage_valid_r && out_valid_r && !out_ready,
    !in_ready,
    "input accepted while pipeline is full")

  // The CRC register only moves when a byte advances into the result register.
  `CCRC_ASSERT_NEXT(a_crc_quiet,
    !advance,
    crc_r == $past(crc_r),
    "CRC register changed without a byte")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the byte-wide configurable CRC engine.
`timescale 1ns / 1ps

module tb_top;
  import ccrc_pkg::*;

  // Tracks the engine's configuration and CRC register, predicts one result per
  // accepted byte and checks each result transfer against the oldest prediction.
  class crc_tracker;
    logic            refl;
    logic [5:0]      width;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init_val;
    logic [CrcW-1:0] crc_reg;
    ccrc_out_t       expected_results[$];
    int              failures;

    function new();
      refl     = RESET_REFLECTED;
      width    = RESET_CRC_WIDTH;
      poly     = RESET_POLYNOMIAL;
      init_val = RESET_INITIAL_VALUE;
      crc_reg  = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CrcW-1:0] val);
      case (idx)
        CFG_REFLECTED:     refl = val[0];
        CFG_CRC_WIDTH:     width = val[5:0];
        CFG_POLYNOMIAL:    poly = val;
        CFG_INITIAL_VALUE: init_val = val;
        default: ;
      endcase
    endfunction

    function bit cfg_invalid();
      logic [63:0] limit;
      if (width < MIN_CRC_WIDTH || width > MAX_CRC_WIDTH) return 1'b1;
      limit = 64'd1 << width;
      return {32'd0, poly} >= limit;
    endfunction

    // Eight shift/XOR steps of one index byte in the register's layout.
    function logic [CrcW-1:0] fold_byte(logic [7:0] idx);
      logic [CrcW-1:0] c;
      logic [CrcW-1:0] p;
      if (refl) begin
        c = {24'd0, idx};
        for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? poly : 32'd0);
        return c;
      end
      p = poly << (32 - int'(width));
      c = {idx, 24'd0};
      for (int k = 0; k < 8; k++) c = (c << 1) ^ (c[31] ? p : 32'd0);
      return {c[7:0], c[15:8], c[23:16], c[31:24]};
    endfunction

    function void note_input(ccrc_in_t item);
      ccrc_out_t r;
      r.message_done = item.last_byte;
      if (cfg_invalid()) begin
        r.crc_value    = '0;
        r.config_error = 1'b1;
      end else begin
        if (item.first_byte) crc_reg = init_val;
        crc_reg        = fold_byte(crc_reg[7:0] ^ item.data_byte) ^ (crc_reg >> 8);
        r.crc_value    = crc_reg;
        r.config_error = 1'b0;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(ccrc_out_t got);
      ccrc_out_t exp;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: crc_value %h", got.crc_value);
        failures++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.crc_value !== exp.crc_value) begin
        $error("crc_value expected %h actual %h", exp.crc_value, got.crc_value);
        failures++;
      end
      if (got.message_done !== exp.message_done) begin
        $error("message_done expected %b actual %b", exp.message_done, got.message_done);
        failures++;
      end
      if (got.config_error !== exp.config_error) begin
        $error("config_error expected %b actual %b", exp.config_error, got.config_error);
        failures++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 40;   // long receiver hold-off, fills both stages
  localparam int DRAIN_CYCLES = 6;    // wait after the last predicted result so that a stray extra result shows up
  localparam int RANDOM_BYTES = 1250;
  localparam int TIMEOUT_NS   = 12 * 400_000;

  // Indexes past the end of the register map; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_INDEX = CFG_INITIAL_VALUE + 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOP_INDEX      = 8'hFF;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ccrc_in_t           in_data;
  logic               out_valid;
  logic               out_ready;
  ccrc_out_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CrcW-1:0]    cfg_data;

  // Flags shared between the stimulus and the receiver process.
  bit sender_quiet;
  bit receiver_quiet;
  bit hold_request;
  int random_bytes_sent;

  crc_tracker tracker = new();

  configurable_crc_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  // The receiver stalls at random about a third of the time, never while the
  // quiet flag is set. When the stimulus asks for a hold-off, it keeps ready low
  // for a long stretch of its own counting so that the engine backs up and
  // drops in_ready while the sender keeps offering bytes.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready = receiver_quiet || ($urandom_range(99) >= 33);
      end
    end
  end

  // Every result transfer is checked at the rising edge at which it happens.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  // Offers one byte, possibly after a random idle gap, and returns at the edge
  // of its transfer. Valid stays high between back-to-back bytes.
  task automatic send_byte(input ccrc_in_t item);
    int gap;
    gap = (!sender_quiet && $urandom_range(99) < 33) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_input(item);
  endtask

  task automatic send_flagged(input logic [7:0] data, input logic first, input logic last);
    ccrc_in_t item;
    item.data_byte  = data;
    item.first_byte = first;
    item.last_byte  = last;
    send_byte(item);
  endtask

  // Configuration writes happen only with nothing in flight.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CrcW-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic refl, input logic [5:0] w,
                            input logic [CrcW-1:0] p, input logic [CrcW-1:0] init);
    write_reg(CFG_REFLECTED, {31'd0, refl});
    write_reg(CFG_CRC_WIDTH, {26'd0, w});
    write_reg(CFG_POLYNOMIAL, p);
    write_reg(CFG_INITIAL_VALUE, init);
  endtask

  // Stops offering bytes and waits until every predicted result has arrived,
  // then keeps waiting for DRAIN_CYCLES so that a stray extra result shows up.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Picks a random setting: mostly valid widths with the extremes favored, now
  // and then an arbitrary width, and sometimes a polynomial that overflows it.
  // The unused upper bits of the one-bit and six-bit registers get noise too.
  task automatic random_config();
    logic [5:0]      w;
    logic [63:0]     mask;
    logic [CrcW-1:0] p;
    logic [CrcW-1:0] noise;
    int              r;
    r = $urandom_range(99);
    if (r < 10) w = 6'($urandom_range(63));
    else if (r < 25) w = MIN_CRC_WIDTH;
    else if (r < 40) w = MAX_CRC_WIDTH;
    else w = 6'($urandom_range(8, 32));
    mask = (w >= 6'd32) ? 64'hFFFF_FFFF : ((64'd1 << w) - 64'd1);
    p = $urandom;
    if ($urandom_range(99) >= 10) p = p & mask[31:0];
    noise = $urandom;
    write_reg(CFG_REFLECTED, $urandom);
    write_reg(CFG_CRC_WIDTH, {noise[31:6], w});
    write_reg(CFG_POLYNOMIAL, p);
    write_reg(CFG_INITIAL_VALUE, $urandom);
    if ($urandom_range(9) == 0) write_reg(CfgIdxW'($urandom_range(4, 255)), $urandom);
  endtask

  // Mostly whole messages with random content; the rest are loose bytes with
  // random first and last marks.
  task automatic send_random_message();
    int       len;
    ccrc_in_t item;
    if ($urandom_range(99) < 85) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        item.data_byte  = 8'($urandom);
        item.first_byte = (i == 0);
        item.last_byte  = (i == len - 1);
        send_byte(item);
      end
      random_bytes_sent += len;
    end else begin
      item.data_byte  = 8'($urandom);
      item.first_byte = 1'($urandom);
      item.last_byte  = 1'($urandom);
      send_byte(item);
      random_bytes_sent++;
    end
  endtask

  initial begin
    int segment;
    int n_msgs;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data           = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    sender_quiet      = 1'b0;
    receiver_quiet    = 1'b0;
    hold_request      = 1'b0;
    random_bytes_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Default reflected CRC-32 with an all-ones start over the usual check
    // string, then the data extremes and a byte inside an open message.
    write_reg(CFG_INITIAL_VALUE, 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++) send_flagged(8'h31 + 8'(i), i == 0, i == 8);
    send_flagged(8'h00, 1'b1, 1'b1);
    send_flagged(8'hFF, 1'b1, 1'b1);
    send_flagged(8'hA5, 1'b0, 1'b0);
    drain();

    // MSB-first at the narrowest and the widest width.
    set_config(1'b0, MIN_CRC_WIDTH, 32'h0000_0007, 32'h0000_0000);
    send_flagged(8'hFF, 1'b1, 1'b0);
    send_flagged(8'h00, 1'b0, 1'b1);
    drain();
    set_config(1'b0, MAX_CRC_WIDTH, 32'h04C1_1DB7, 32'hFFFF_FFFF);
    send_flagged(8'h31, 1'b1, 1'b0);
    send_flagged(8'h32, 1'b0, 1'b1);
    drain();

    // A start value with bits above the width; they are not masked off.
    set_config(1'b1, 6'd16, 32'h0000_A001, 32'hFFFF_1234);
    send_flagged(8'h5A, 1'b1, 1'b0);
    send_flagged(8'hC3, 1'b0, 1'b0);
    drain();

    // Invalid settings: width too small, too large, far too large, and a
    // polynomial that does not fit. The CRC register must survive them all.
    write_reg(CFG_CRC_WIDTH, 32'd7);
    send_flagged(8'h12, 1'b1, 1'b1);
    drain();
    write_reg(CFG_CRC_WIDTH, 32'd33);
    send_flagged(8'h34, 1'b0, 1'b1);
    drain();
    write_reg(CFG_CRC_WIDTH, 32'hFFFF_FFFF);
    send_flagged(8'h56, 1'b1, 1'b0);
    drain();
    write_reg(CFG_CRC_WIDTH, 32'd16);
    write_reg(CFG_POLYNOMIAL, 32'h0001_0000);
    send_flagged(8'h78, 1'b1, 1'b1);
    drain();

    // Writes past the register map change nothing. The all-ones polynomial at
    // full width is valid, and the message carries on from the kept register.
    write_reg(CFG_TOP_INDEX, 32'hFFFF_FFFF);
    write_reg(CFG_UNMAPPED_INDEX, 32'h0000_0000);
    write_reg(CFG_CRC_WIDTH, {26'd0, MAX_CRC_WIDTH});
    write_reg(CFG_POLYNOMIAL, 32'hFFFF_FFFF);
    send_flagged(8'h9B, 1'b0, 1'b0);
    send_flagged(8'hE7, 1'b0, 1'b1);
    drain();

    // Random part, one setting per segment. Segment 1 holds off the receiver
    // while the sender streams, segment 2 pauses the sender mid-stream until
    // everything is back, and segment 3 runs with no idling on either side.
    segment = 0;
    while (random_bytes_sent < RANDOM_BYTES) begin
      sender_quiet   = (segment == 1) || (segment == 3);
      receiver_quiet = (segment == 3);
      random_config();
      n_msgs = $urandom_range(10, 30);
      for (int m = 0; m < n_msgs; m++) begin
        if (segment == 1 && m == 3) hold_request = 1'b1;
        if (segment == 2 && m == n_msgs / 2) drain();
        send_random_message();
      end
      drain();
      segment++;
    end

    if (tracker.failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: configurable_crc_engine.f
+incdir+rtl
rtl/ccrc_pkg.sv
rtl/ccrc_cfg_regs.sv
rtl/ccrc_fold.sv
rtl/configurable_crc_engine.sv
tb/tb_top.sv
